>>> rtl/clbs_pkg.sv
`timescale 1ns / 1ps
// clbs_pkg: shared types, phase codes and constants for the character lcd bus sequencer
// no dependencies; used by clbs_cfg, clbs_step and character_lcd_bus_sequencer
package clbs_pkg;

    // sequencer phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_POLL   = 3'd1;
    localparam logic [2:0] PH_GAP    = 3'd2;
    localparam logic [2:0] PH_SETTLE = 3'd3;
    localparam logic [2:0] PH_WHIGH  = 3'd4;
    localparam logic [2:0] PH_WLOW   = 3'd5;

    // request command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_INSTR = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;
    localparam logic [1:0] CMD_INIT  = 2'd3;

    // configuration register indexes
    localparam logic REG_UNIT_TICKS   = 1'b0;
    localparam logic REG_SETTLE_TICKS = 1'b1;

    // reset values of the timing registers
    localparam logic [9:0]  UNIT_TICKS_RST   = 10'd42;
    localparam logic [15:0] SETTLE_TICKS_RST = 16'd1344;

    // busy flag sits on d7
    localparam int unsigned BUSY_BIT = 7;

    // number of init steps, last value of init_step while init runs
    localparam logic [2:0] INIT_LAST = 3'd4;

    typedef struct packed {
        logic [9:0]  unit_ticks;
        logic [15:0] settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [2:0]  init_step;
        logic [15:0] tick_count;
        logic [7:0]  held_byte;
        logic        held_select;
        logic        poll_after;
    } state_t;

    typedef struct packed {
        logic       accepted;
        logic       ready_res;
        logic       bus_drive;
        logic [7:0] bus_out;
        logic       pin_rw;
        logic       pin_rs;
        logic       pin_e;
    } result_t;

    // init sequence: function set, display on, clear, entry mode
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h38;
            2'd1:    b = 8'h0C;
            2'd2:    b = 8'h01;
            default: b = 8'h06;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/clbs_cfg.sv
`timescale 1ns / 1ps
// clbs_cfg: timing configuration registers written over the config channel
// depends on clbs_pkg
module clbs_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    output clbs_pkg::cfg_t      cfg
);

    logic [9:0]  unit_ticks_reg;
    logic [15:0] settle_ticks_reg;

    assign cfg_ready = 1'b1;

    // register writes, always taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_ticks_reg   <= clbs_pkg::UNIT_TICKS_RST;
            settle_ticks_reg <= clbs_pkg::SETTLE_TICKS_RST;
        end else if (cfg_valid) begin
            if (cfg_index == clbs_pkg::REG_UNIT_TICKS) begin
                unit_ticks_reg <= cfg_data[9:0];
            end else begin
                settle_ticks_reg <= cfg_data;
            end
        end
    end

    assign cfg.unit_ticks   = unit_ticks_reg;
    assign cfg.settle_ticks = settle_ticks_reg;

endmodule

>>> rtl/clbs_step.sv
`timescale 1ns / 1ps
// clbs_step: next-state and pin logic for one clock tick of the lcd bus
// depends on clbs_pkg
module clbs_step (
    input  clbs_pkg::cfg_t      cfg,
    input  clbs_pkg::state_t    st,
    input  logic [1:0]          command,
    input  logic [7:0]          data_byte,
    input  logic [7:0]          bus_in,
    output clbs_pkg::state_t    st_next,
    output clbs_pkg::result_t   res
);

    logic [9:0]  unit_len;
    logic [10:0] poll_len;
    logic [15:0] tc_inc;
    logic        tc_wrap;
    logic        done_unit;
    logic        done_poll;
    logic        done_settle;
    logic        settle_zero;
    logic        init_more;

    // phase lengths and tick counter compares
    always_comb begin
        unit_len    = (cfg.unit_ticks == 10'd0) ? 10'd1 : cfg.unit_ticks;
        poll_len    = {unit_len, 1'b0};
        tc_inc      = st.tick_count + 16'd1;
        tc_wrap     = (tc_inc == 16'd0);
        done_unit   = (tc_inc >= {6'd0, unit_len}) || tc_wrap;
        done_poll   = (tc_inc >= {5'd0, poll_len}) || tc_wrap;
        done_settle = (tc_inc >= cfg.settle_ticks) || tc_wrap;
        settle_zero = (cfg.settle_ticks == 16'd0);
        init_more   = (st.init_step >= 3'd1) && (st.init_step <= 3'd3);
    end

    // sequencer
    always_comb begin
        logic do_after;
        do_after = 1'b0;

        st_next = st;
        res = '0;
        res.pin_rw = 1'b1;

        case (st.phase)
            clbs_pkg::PH_POLL: begin
                res.pin_e = 1'b1;
                st_next.tick_count = tc_inc;
                if (done_poll) begin
                    if (bus_in[clbs_pkg::BUSY_BIT]) begin
                        st_next.phase      = clbs_pkg::PH_GAP;
                        st_next.tick_count = '0;
                    end else if (settle_zero) begin
                        do_after = 1'b1;
                    end else begin
                        st_next.phase      = clbs_pkg::PH_SETTLE;
                        st_next.tick_count = '0;
                    end
                end
            end
            clbs_pkg::PH_GAP: begin
                st_next.tick_count = tc_inc;
                if (done_unit) begin
                    st_next.phase      = clbs_pkg::PH_POLL;
                    st_next.tick_count = '0;
                end
            end
            clbs_pkg::PH_SETTLE: begin
                st_next.tick_count = tc_inc;
                if (done_settle) begin
                    do_after = 1'b1;
                end
            end
            clbs_pkg::PH_WHIGH, clbs_pkg::PH_WLOW: begin
                res.pin_e     = (st.phase == clbs_pkg::PH_WHIGH);
                res.pin_rs    = st.held_select;
                res.pin_rw    = 1'b0;
                res.bus_out   = st.held_byte;
                res.bus_drive = 1'b1;
                st_next.tick_count = tc_inc;
                if (done_unit) begin
                    st_next.tick_count = '0;
                    if (st.phase == clbs_pkg::PH_WHIGH) begin
                        st_next.phase = clbs_pkg::PH_WLOW;
                    end else begin
                        st_next.phase      = clbs_pkg::PH_POLL;
                        st_next.poll_after = 1'b1;
                    end
                end
            end
            default: begin
                st_next.phase = clbs_pkg::PH_IDLE;
                res.ready_res = 1'b1;
                if (command != clbs_pkg::CMD_TICK) begin
                    res.accepted       = 1'b1;
                    st_next.poll_after = 1'b0;
                    st_next.phase      = clbs_pkg::PH_POLL;
                    st_next.tick_count = '0;
                    st_next.held_select = 1'b0;
                    if (command == clbs_pkg::CMD_INIT) begin
                        st_next.init_step = 3'd1;
                        st_next.held_byte = clbs_pkg::init_byte(2'd0);
                    end else begin
                        st_next.init_step   = 3'd0;
                        st_next.held_byte   = data_byte;
                        st_next.held_select = (command == clbs_pkg::CMD_DATA);
                    end
                end
            end
        endcase

        // end of settle wait: write, next init byte, or back to idle
        if (do_after) begin
            st_next.tick_count = '0;
            if (!st.poll_after) begin
                st_next.phase = clbs_pkg::PH_WHIGH;
            end else if (init_more) begin
                st_next.held_byte   = clbs_pkg::init_byte(st.init_step[1:0]);
                st_next.held_select = 1'b0;
                st_next.init_step   = st.init_step + 3'd1;
                st_next.phase       = clbs_pkg::PH_WHIGH;
            end else begin
                st_next.init_step  = 3'd0;
                st_next.poll_after = 1'b0;
                st_next.phase      = clbs_pkg::PH_IDLE;
            end
        end
    end

endmodule

>>> rtl/character_lcd_bus_sequencer.sv
`timescale 1ns / 1ps
// character_lcd_bus_sequencer: top level, state and result registers, stream ports
// depends on clbs_pkg, clbs_cfg, clbs_step

// Each request on the input stream is one clock tick of an 8-bit character
// display bus, and each yields exactly one result giving the pin levels for
// that tick. A request is taken every cycle while the result register is empty
// or being emptied, so the block runs at one item per clock; the loop from the
// sequencer state through the tick logic back to the state register holds no
// other register. Timing registers (unit_ticks at index 0, settle_ticks at
// index 1) are written over the cfg channel, which is always ready, and
// should only change while no request is in flight; a phase that is
// shortened below its current count ends on its next tick.
module character_lcd_bus_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // command[1:0], data_byte[9:2], bus_in[17:10], zero pad
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pin_e[0], pin_rs[1], pin_rw[2], bus_out[10:3],
                                   // bus_drive[11], ready_res[12], accepted[13], zero pad
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    clbs_pkg::cfg_t    cfg;
    clbs_pkg::state_t  st_reg;
    clbs_pkg::state_t  st_next;
    clbs_pkg::result_t res_reg;
    clbs_pkg::result_t res_next;
    logic              m_tvalid_reg;
    logic              s_take;

    clbs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    clbs_step u_step (
        .cfg       (cfg),
        .st        (st_reg),
        .command   (s_tdata[1:0]),
        .data_byte (s_tdata[9:2]),
        .bus_in    (s_tdata[17:10]),
        .st_next   (st_next),
        .res       (res_next)
    );

    // take a request when the result slot is free or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_take   = s_tvalid && s_tready;

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (s_take) begin
            st_reg <= st_next;
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_take) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, res_reg};

`ifndef SYNTHESIS
    // a request is only ever taken when the tick began in idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && res_reg.accepted |-> res_reg.ready_res)
        else $error("accepted request without idle");

    // a released bus carries zero and the pins show a read
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !res_reg.bus_drive |-> res_reg.bus_out == 8'd0 && res_reg.pin_rw)
        else $error("released bus not clean");

    // an accepted request starts polling on the next tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && res_next.accepted |=> st_reg.phase == clbs_pkg::PH_POLL)
        else $error("accepted request did not start a poll");

    // init step never runs past the last init byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.init_step <= clbs_pkg::INIT_LAST)
        else $error("init step out of range");

    // state only moves when a request is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_take |=> $stable(st_reg))
        else $error("state changed without a request");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for character_lcd_bus_sequencer, one request per bus tick
// needs clbs_pkg and the sequencer rtl; predicts every pin result and checks it in order

module tb_top;

    localparam int IDLE_PCT     = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_TICKS = 520;
    // init bytes, first one in the low byte
    localparam logic [31:0] INIT_BYTES = 32'h06_01_0C_38;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] dbyte;
        logic [7:0] bus;
    } tick_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    wire         s_tready;
    logic [23:0] s_tdata   = '0;
    wire         m_tvalid;
    logic        m_tready  = 1'b0;
    wire  [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic        cfg_index = clbs_pkg::REG_UNIT_TICKS;
    logic [15:0] cfg_data  = '0;

    // stimulus and scoreboard
    tick_t             tick_q[$];
    tick_t             cur_tick;
    clbs_pkg::result_t pins_due[$];
    int      ticks_queued = 0;
    int      ticks_taken  = 0;
    int      errors       = 0;
    bit      sent         = 1'b0;
    bit      no_idle      = 1'b0;
    bit      hold_go      = 1'b0;
    int      hold_left    = 0;

    // predictor state and timing registers
    logic [2:0]  seq_phase  = clbs_pkg::PH_IDLE;
    logic [2:0]  init_idx   = 3'd0;
    logic [15:0] tick_cnt   = 16'd0;
    logic [7:0]  held_byte  = 8'd0;
    logic        held_rs    = 1'b0;
    logic        poll_after = 1'b0;
    logic [9:0]  unit_cfg   = clbs_pkg::UNIT_TICKS_RST;
    logic [15:0] settle_cfg = clbs_pkg::SETTLE_TICKS_RST;

    character_lcd_bus_sequencer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic int unit_len();
        return (unit_cfg == 10'd0) ? 1 : int'(unit_cfg);
    endfunction

    // advance the phase counter, a wrap to zero also ends the phase
    function automatic bit count_reached(int len);
        tick_cnt = tick_cnt + 16'd1;
        return (int'(tick_cnt) >= len) || (tick_cnt == 16'd0);
    endfunction

    function automatic void enter_phase(logic [2:0] p);
        seq_phase = p;
        tick_cnt  = 16'd0;
    endfunction

    // display ready and settled: write the held byte, next init byte, or finish
    function automatic void settle_done();
        if (!poll_after) begin
            enter_phase(clbs_pkg::PH_WHIGH);
        end else if (init_idx >= 3'd1 && init_idx <= 3'd3) begin
            held_byte = INIT_BYTES[8 * init_idx[1:0] +: 8];
            held_rs   = 1'b0;
            init_idx  = init_idx + 3'd1;
            enter_phase(clbs_pkg::PH_WHIGH);
        end else begin
            init_idx   = 3'd0;
            poll_after = 1'b0;
            enter_phase(clbs_pkg::PH_IDLE);
        end
    endfunction

    // pin levels for one bus tick, state moved on by one tick
    function automatic clbs_pkg::result_t pins_for_tick(tick_t t);
        clbs_pkg::result_t r;
        logic [2:0]        was;
        r        = '0;
        r.pin_rw = 1'b1;
        was      = seq_phase;
        case (seq_phase)
            clbs_pkg::PH_POLL: begin
                r.pin_e = 1'b1;
                if (count_reached(2 * unit_len())) begin
                    if (t.bus[clbs_pkg::BUSY_BIT])
                        enter_phase(clbs_pkg::PH_GAP);
                    else if (settle_cfg == 16'd0)
                        settle_done();
                    else
                        enter_phase(clbs_pkg::PH_SETTLE);
                end
            end
            clbs_pkg::PH_GAP: begin
                if (count_reached(unit_len()))
                    enter_phase(clbs_pkg::PH_POLL);
            end
            clbs_pkg::PH_SETTLE: begin
                if (count_reached(int'(settle_cfg)))
                    settle_done();
            end
            clbs_pkg::PH_WHIGH, clbs_pkg::PH_WLOW: begin
                r.pin_e     = (was == clbs_pkg::PH_WHIGH);
                r.pin_rs    = held_rs;
                r.pin_rw    = 1'b0;
                r.bus_out   = held_byte;
                r.bus_drive = 1'b1;
                if (count_reached(unit_len())) begin
                    if (was == clbs_pkg::PH_WHIGH) begin
                        enter_phase(clbs_pkg::PH_WLOW);
                    end else begin
                        poll_after = 1'b1;
                        enter_phase(clbs_pkg::PH_POLL);
                    end
                end
            end
            default: begin
                seq_phase   = clbs_pkg::PH_IDLE;
                r.ready_res = 1'b1;
                if (t.cmd != clbs_pkg::CMD_TICK) begin
                    r.accepted = 1'b1;
                    poll_after = 1'b0;
                    if (t.cmd == clbs_pkg::CMD_INIT) begin
                        init_idx  = 3'd1;
                        held_byte = INIT_BYTES[7:0];
                        held_rs   = 1'b0;
                    end else begin
                        init_idx  = 3'd0;
                        held_byte = t.dbyte;
                        held_rs   = (t.cmd == clbs_pkg::CMD_DATA);
                    end
                    enter_phase(clbs_pkg::PH_POLL);
                end
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- driver

    // offer the next tick at the falling edge, with random gaps
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || sent)) begin
            sent = 1'b0;
            if (tick_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                cur_tick = tick_q.pop_front();
                s_tdata  <= {6'd0, cur_tick.bus, cur_tick.dbyte, cur_tick.cmd};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // request taken: predict its pins
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            pins_due.push_back(pins_for_tick(cur_tick));
            ticks_taken = ticks_taken + 1;
            sent        = 1'b1;
        end
    end

    // ---------------------------------------------------------------- receiver

    // random back-pressure, plus one long hold-off on demand
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic check_pin(string name, int want, int got);
        if (want != got) begin
            errors = errors + 1;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // compare each result with the oldest prediction
    always @(posedge aclk) begin
        clbs_pkg::result_t got;
        clbs_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = clbs_pkg::result_t'(m_tdata[13:0]);
            if (pins_due.size() == 0) begin
                errors = errors + 1;
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
            end else begin
                want = pins_due.pop_front();
                check_pin("pin_e", want.pin_e, got.pin_e);
                check_pin("pin_rs", want.pin_rs, got.pin_rs);
                check_pin("pin_rw", want.pin_rw, got.pin_rw);
                check_pin("bus_out", want.bus_out, got.bus_out);
                check_pin("bus_drive", want.bus_drive, got.bus_drive);
                check_pin("ready_res", want.ready_res, got.ready_res);
                check_pin("accepted", want.accepted, got.accepted);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic queue_tick(logic [1:0] cmd, logic [7:0] dbyte, logic [7:0] bus);
        tick_t t;
        t.cmd   = cmd;
        t.dbyte = dbyte;
        t.bus   = bus;
        tick_q.push_back(t);
        ticks_queued = ticks_queued + 1;
    endtask

    task automatic wait_taken();
        while (ticks_taken != ticks_queued)
            @(negedge aclk);
    endtask

    task automatic wait_drained();
        wait_taken();
        while (pins_due.size() != 0)
            @(negedge aclk);
    endtask

    // a batch of bus ticks; noise requests hit the sequencer while busy
    task automatic run_ticks(int count, int busy_pct, int noise_pct);
        logic [7:0] bus;
        logic [1:0] cmd;
        repeat (count) begin
            bus                     = 8'($urandom);
            bus[clbs_pkg::BUSY_BIT] = ($urandom_range(99) < busy_pct);
            cmd                     = ($urandom_range(99) < noise_pct) ?
                                      2'($urandom_range(3, 1)) : clbs_pkg::CMD_TICK;
            queue_tick(cmd, 8'($urandom), bus);
        end
        wait_taken();
    endtask

    // feed bus ticks until the sequencer is back in idle
    task automatic run_to_idle(int busy_pct, int noise_pct, int batch);
        wait_taken();
        while (seq_phase != clbs_pkg::PH_IDLE)
            run_ticks(batch, busy_pct, noise_pct);
    endtask

    task automatic do_request(logic [1:0] cmd, logic [7:0] dbyte,
                              int busy_pct, int noise_pct, int batch);
        queue_tick(cmd, dbyte, 8'($urandom));
        run_to_idle(busy_pct, noise_pct, batch);
    endtask

    // timing register write, only with nothing in flight
    task automatic write_reg(logic idx, logic [15:0] val);
        wait_drained();
        repeat (4) @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == clbs_pkg::REG_UNIT_TICKS)
            unit_cfg = val[9:0];
        else
            settle_cfg = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int         start;
        bit         hold_used;
        logic [1:0] cmd;
        hold_used = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset timing, tick-only in idle, one data write, no idling;
        // the long settle is cut short by shorter timing
        no_idle = 1'b1;
        queue_tick(clbs_pkg::CMD_TICK, 8'hFF, 8'h00);
        queue_tick(clbs_pkg::CMD_TICK, 8'h00, 8'hFF);
        queue_tick(clbs_pkg::CMD_DATA, 8'hFF, 8'($urandom));
        run_ticks(120, 40, 5);
        write_reg(clbs_pkg::REG_UNIT_TICKS, 16'd1);
        write_reg(clbs_pkg::REG_SETTLE_TICKS, 16'd1);
        run_to_idle(40, 5, 16);
        no_idle = 1'b0;

        // shortest unit and zero settle
        write_reg(clbs_pkg::REG_UNIT_TICKS, 16'd1);
        write_reg(clbs_pkg::REG_SETTLE_TICKS, 16'd0);
        do_request(clbs_pkg::CMD_INSTR, 8'h00, 30, 10, 4);
        do_request(clbs_pkg::CMD_INIT, 8'h00, 30, 10, 4);
        do_request(clbs_pkg::CMD_DATA, 8'hA5, 30, 10, 4);
        do_request(clbs_pkg::CMD_INSTR, 8'h5A, 30, 10, 4);

        // unit of zero behaves as one
        write_reg(clbs_pkg::REG_UNIT_TICKS, 16'd0);
        write_reg(clbs_pkg::REG_SETTLE_TICKS, 16'd1);
        do_request(clbs_pkg::CMD_DATA, 8'h00, 30, 10, 4);
        do_request(clbs_pkg::CMD_INIT, 8'hFF, 30, 10, 4);

        // longest unit, then shortened in the middle of the poll
        write_reg(clbs_pkg::REG_UNIT_TICKS, 16'd1023);
        write_reg(clbs_pkg::REG_SETTLE_TICKS, 16'd0);
        queue_tick(clbs_pkg::CMD_INSTR, 8'hC3, 8'($urandom));
        run_ticks(40, 5, 0);
        write_reg(clbs_pkg::REG_UNIT_TICKS, 16'd2);
        run_to_idle(5, 0, 8);

        // longest settle, then shortened in the middle of the wait
        write_reg(clbs_pkg::REG_UNIT_TICKS, 16'd1);
        write_reg(clbs_pkg::REG_SETTLE_TICKS, 16'hFFFF);
        queue_tick(clbs_pkg::CMD_DATA, 8'h3C, 8'($urandom));
        run_ticks(40, 20, 0);
        write_reg(clbs_pkg::REG_SETTLE_TICKS, 16'd3);
        run_to_idle(20, 0, 8);

        // random sequences with short timing
        start = ticks_queued;
        while (ticks_queued - start < RANDOM_TICKS) begin
            write_reg(clbs_pkg::REG_UNIT_TICKS, 16'($urandom_range(3, 0)));
            write_reg(clbs_pkg::REG_SETTLE_TICKS,
                      ($urandom_range(99) < 30) ? 16'd0 : 16'($urandom_range(8, 1)));
            // long receiver hold-off while requests keep coming
            if (!hold_used) begin
                hold_go   = 1'b1;
                hold_used = 1'b1;
            end
            repeat (2) begin
                cmd = ($urandom_range(99) < 10) ? clbs_pkg::CMD_TICK :
                                                  2'($urandom_range(3, 1));
                do_request(cmd, 8'($urandom), 25, 10, 4);
            end
        end

        wait_drained();
        repeat (10) @(negedge aclk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial begin
        #(64'd2_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> character_lcd_bus_sequencer.f
rtl/clbs_pkg.sv
rtl/clbs_cfg.sv
rtl/clbs_step.sv
rtl/character_lcd_bus_sequencer.sv
dv/tb_top.sv
